// ----- rtl/color_adjust_matrix_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Color adjust matrix generator assertion macros
// Shared concurrent check forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_ADJUST_MATRIX_GENERATOR_ASSERT_SVH
`define COLOR_ADJUST_MATRIX_GENERATOR_ASSERT_SVH

// check that post holds whenever pre holds
`define CAMG_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("camg: implication check failed");

// check that post holds a fixed number of cycles after pre
`define CAMG_ASSERT_DELAY(label, pre, cycles, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##cycles (post)) \
      else $error("camg: delayed check failed");

`endif

// ----- rtl/camg_pkg.sv -----
// ----------------------------------------------------------------------------
// Color adjust matrix generator package
// Widths, fixed-point conversion constants, trig tables and helper functions.
// ----------------------------------------------------------------------------
package camg_pkg;

   localparam int SINE_TABLE_SIZE = 256;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int WORK_FRAC       = 24;

   localparam int QTR = SINE_TABLE_SIZE / 4;
   localparam int QW  = $clog2(QTR);
   localparam int KW  = $clog2(SINE_TABLE_SIZE);

   localparam int WW = 32;
   localparam int CW = 28;
   localparam int PW = WW + CW;
   localparam int SW = PW + 2;
   localparam int OW = 20;
   localparam int FW = 16;

   localparam int PIPE_DEPTH = 11;

   typedef logic signed [WW-1:0] work_type;
   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] sum_type;
   typedef logic signed [OW-1:0] out_type;
   typedef logic [24:0]          trig_type;
   typedef trig_type             trig_tab_type [QTR];

   localparam logic [2:0] SPACE_RGB       = 3'd0;
   localparam logic [2:0] SPACE_BT601     = 3'd1;
   localparam logic [2:0] SPACE_BT709     = 3'd2;
   localparam logic [2:0] SPACE_SMPTE240M = 3'd3;
   localparam logic [1:0] RANGE_TV        = 2'd1;
   localparam logic [1:0] RANGE_PC        = 2'd2;

   typedef enum logic [2:0] {
      CS_601_TV,
      CS_601_PC,
      CS_709_TV,
      CS_709_PC,
      CS_240_TV,
      CS_240_PC
   } coefset_type;

   typedef struct packed {
      coefset_type cset;
      logic        rgb;
      logic        tv;
      logic        ident;
   } ctl_type;

   localparam longint ONE = longint'(1) << WORK_FRAC;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam longint OUT_MAX = 524287;
   localparam longint OUT_MIN = -524288;
   localparam int EMIT_SHIFT = WORK_FRAC - COEF_FRAC_BITS;
   localparam longint EMIT_HALF = longint'(1) << (EMIT_SHIFT - 1);
   localparam longint HALF_WORK = longint'(1) << (WORK_FRAC - 1);
   localparam longint IDENT_RAW = longint'(1) << COEF_FRAC_BITS;
   localparam out_type IDENT_OUT = out_type'((IDENT_RAW > OUT_MAX) ? OUT_MAX : IDENT_RAW);

   // luma/chroma weights in units of 1/10000
   localparam longint KB_601 = 1140;
   localparam longint KR_601 = 2990;
   localparam longint KG_601 = 10000 - KB_601 - KR_601;
   localparam longint KB_709 = 722;
   localparam longint KR_709 = 2126;
   localparam longint KG_709 = 10000 - KB_709 - KR_709;
   localparam longint KB_240 = 870;
   localparam longint KR_240 = 2120;
   localparam longint KG_240 = 10000 - KB_240 - KR_240;

   localparam longint DT  = 255;
   localparam longint DYT = 219;
   localparam longint DCT = 224;

   localparam longint E00_TV = (2 * DT * ONE + DYT) / (2 * DYT);
   localparam longint E00_PC = ONE;

   // nonzero YCbCr-to-RGB entries: [0..2][0], [0][2], [1][1], [1][2], [2][1]
   localparam longint Y2R_TAB [6][5] = '{
      '{E00_TV,
        (4 * DT * (10000 - KR_601) * ONE + 10000 * DCT) / (20000 * DCT),
        -((4 * DT * (10000 - KB_601) * KB_601 * ONE + DCT * 10000 * KG_601 - 1)
          / (2 * DCT * 10000 * KG_601)),
        -((4 * DT * (10000 - KR_601) * KR_601 * ONE + DCT * 10000 * KG_601 - 1)
          / (2 * DCT * 10000 * KG_601)),
        (4 * DT * (10000 - KB_601) * ONE + 10000 * DCT) / (20000 * DCT)},
      '{E00_PC,
        (4 * (10000 - KR_601) * ONE + 10000) / 20000,
        -((4 * (10000 - KB_601) * KB_601 * ONE + 10000 * KG_601 - 1)
          / (2 * 10000 * KG_601)),
        -((4 * (10000 - KR_601) * KR_601 * ONE + 10000 * KG_601 - 1)
          / (2 * 10000 * KG_601)),
        (4 * (10000 - KB_601) * ONE + 10000) / 20000},
      '{E00_TV,
        (4 * DT * (10000 - KR_709) * ONE + 10000 * DCT) / (20000 * DCT),
        -((4 * DT * (10000 - KB_709) * KB_709 * ONE + DCT * 10000 * KG_709 - 1)
          / (2 * DCT * 10000 * KG_709)),
        -((4 * DT * (10000 - KR_709) * KR_709 * ONE + DCT * 10000 * KG_709 - 1)
          / (2 * DCT * 10000 * KG_709)),
        (4 * DT * (10000 - KB_709) * ONE + 10000 * DCT) / (20000 * DCT)},
      '{E00_PC,
        (4 * (10000 - KR_709) * ONE + 10000) / 20000,
        -((4 * (10000 - KB_709) * KB_709 * ONE + 10000 * KG_709 - 1)
          / (2 * 10000 * KG_709)),
        -((4 * (10000 - KR_709) * KR_709 * ONE + 10000 * KG_709 - 1)
          / (2 * 10000 * KG_709)),
        (4 * (10000 - KB_709) * ONE + 10000) / 20000},
      '{E00_TV,
        (4 * DT * (10000 - KR_240) * ONE + 10000 * DCT) / (20000 * DCT),
        -((4 * DT * (10000 - KB_240) * KB_240 * ONE + DCT * 10000 * KG_240 - 1)
          / (2 * DCT * 10000 * KG_240)),
        -((4 * DT * (10000 - KR_240) * KR_240 * ONE + DCT * 10000 * KG_240 - 1)
          / (2 * DCT * 10000 * KG_240)),
        (4 * DT * (10000 - KB_240) * ONE + 10000 * DCT) / (20000 * DCT)},
      '{E00_PC,
        (4 * (10000 - KR_240) * ONE + 10000) / 20000,
        -((4 * (10000 - KB_240) * KB_240 * ONE + 10000 * KG_240 - 1)
          / (2 * 10000 * KG_240)),
        -((4 * (10000 - KR_240) * KR_240 * ONE + 10000 * KG_240 - 1)
          / (2 * 10000 * KG_240)),
        (4 * (10000 - KB_240) * ONE + 10000) / 20000}
   };

   // RGB-to-YCbCr, BT.601 TV range
   localparam longint R2Y_TAB [3][3] = '{
      '{(2 * DYT * KR_601 * ONE + DT * 10000) / (2 * DT * 10000),
        (2 * DYT * KG_601 * ONE + DT * 10000) / (2 * DT * 10000),
        (2 * DYT * KB_601 * ONE + DT * 10000) / (2 * DT * 10000)},
      '{-((2 * DCT * KR_601 * ONE + 2 * DT * (10000 - KB_601) - 1)
          / (4 * DT * (10000 - KB_601))),
        -((2 * DCT * KG_601 * ONE + 2 * DT * (10000 - KB_601) - 1)
          / (4 * DT * (10000 - KB_601))),
        (2 * DCT * ONE + 2 * DT) / (4 * DT)},
      '{(2 * DCT * ONE + 2 * DT) / (4 * DT),
        -((2 * DCT * KG_601 * ONE + 2 * DT * (10000 - KR_601) - 1)
          / (4 * DT * (10000 - KR_601))),
        -((2 * DCT * KB_601 * ONE + 2 * DT * (10000 - KR_601) - 1)
          / (4 * DT * (10000 - KR_601)))}
   };

   localparam coef_type Y1W_TV = coef_type'((2 * 16 * ONE + DT) / (2 * DT));
   localparam coef_type CMW_TV = coef_type'((2 * 256 * ONE + 2 * DT) / (4 * DT));
   localparam coef_type CMW_PC = coef_type'((2 * ONE + 2) / 4);

   function automatic longint unsigned sin_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
   endfunction

   function automatic trig_tab_type trig_table(input bit want_cos);
      trig_tab_type    t;
      longint unsigned x;
      longint unsigned v;
      for (int j = 0; j < QTR; j++) begin
         x = (longint'(4 * j) * HALF_PI_Q30 + SINE_TABLE_SIZE / 2) / SINE_TABLE_SIZE;
         if (want_cos) begin
            x = HALF_PI_Q30 - x;
         end
         v    = sin_q30(x);
         t[j] = trig_type'((v + 32) >> 6);
      end
      return t;
   endfunction

   localparam trig_tab_type SIN_TAB = trig_table(1'b0);
   localparam trig_tab_type COS_TAB = trig_table(1'b1);

   function automatic coef_type y2r_coef(input coefset_type s, input int i, input int k);
      int     r;
      longint v;
      unique case (s)
         CS_601_TV: r = 0;
         CS_601_PC: r = 1;
         CS_709_TV: r = 2;
         CS_709_PC: r = 3;
         CS_240_TV: r = 4;
         CS_240_PC: r = 5;
         default:   r = 0;
      endcase
      v = 0;
      if (k == 0) begin
         v = Y2R_TAB[r][0];
      end else if (i == 0 && k == 2) begin
         v = Y2R_TAB[r][1];
      end else if (i == 1 && k == 1) begin
         v = Y2R_TAB[r][2];
      end else if (i == 1 && k == 2) begin
         v = Y2R_TAB[r][3];
      end else if (i == 2 && k == 1) begin
         v = Y2R_TAB[r][4];
      end
      return coef_type'(v);
   endfunction

   function automatic work_type round_work(input sum_type v);
      sum_type t;
      t = v + sum_type'(HALF_WORK);
      return work_type'(t >>> WORK_FRAC);
   endfunction

   function automatic out_type emit_out(input work_type w);
      work_type t;
      t = (w + work_type'(EMIT_HALF)) >>> EMIT_SHIFT;
      if (t > work_type'(OUT_MAX)) begin
         return out_type'(OUT_MAX);
      end else if (t < work_type'(OUT_MIN)) begin
         return out_type'(OUT_MIN);
      end
      return out_type'(t);
   endfunction

endpackage

// ----- rtl/color_adjust_matrix_generator.sv -----
// ----------------------------------------------------------------------------
// Color adjust matrix generator
// Builds a 3x3 color matrix and offset vector from color space, level range
// and brightness, saturation, hue and contrast controls.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low;
//   its fields are req_color_space, req_level_range and the four Q1.14
//   picture controls. Nine Q5.14 matrix entries and three offsets appear on
//   the rsp_ ports for one cycle, marked by rsp_strobe.
//   A new command is taken every cycle while reset is low; the rate is set by
//   the eleven-stage multiply/round pipeline, one beat per stage per cycle.
//   busy follows reset only. Reset empties the pipeline: commands in flight
//   are dropped and no strobe follows them. The receiver cannot stall; every
//   result is shown for exactly one cycle.
//   Unknown color spaces and the auto or unknown level range give an
//   identity matrix with zero offsets.
// ----------------------------------------------------------------------------
module color_adjust_matrix_generator
   import camg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_color_space,
   input  logic [1:0]           req_level_range,
   input  logic signed [FW-1:0] req_brightness,
   input  logic signed [FW-1:0] req_saturation_adjust,
   input  logic signed [FW-1:0] req_hue_adjust,
   input  logic signed [FW-1:0] req_contrast_adjust,
   output logic                 rsp_strobe,
   output out_type              rsp_m00,
   output out_type              rsp_m01,
   output out_type              rsp_m02,
   output out_type              rsp_m10,
   output out_type              rsp_m11,
   output out_type              rsp_m12,
   output out_type              rsp_m20,
   output out_type              rsp_m21,
   output out_type              rsp_m22,
   output out_type              rsp_offset_red,
   output out_type              rsp_offset_green,
   output out_type              rsp_offset_blue
);

   `include "color_adjust_matrix_generator_assert.svh"

   logic                       accept;
   logic [PIPE_DEPTH:1]        vld_ff;
   logic [PIPE_DEPTH:1]        vld_in;
   ctl_type                    ctl_ff [2:9];
   ctl_type                    ctl_in;

   logic [2:0]                 s1_space_ff;
   logic [1:0]                 s1_range_ff;
   logic signed [FW-1:0]       s1_bright_ff;
   logic signed [FW-1:0]       s1_sat_ff;
   logic signed [FW-1:0]       s1_hue_ff;
   logic signed [FW-1:0]       s1_con_ff;

   logic [FW-1:0]              s2_sat_ff, s2_sat_in;
   logic [FW-1:0]              s2_con_ff, s2_con_in;
   logic signed [FW-1:0]       s2_bright_ff, s2_bright_in;
   logic [KW-1:0]              s2_kk_ff, s2_kk_in;

   logic [FW-1:0]              cpipe_ff [3:6];
   logic signed [FW-1:0]       bpipe_ff [3:7];

   work_type                   s3_sn_ff, s3_sn_in;
   work_type                   s3_cn_ff, s3_cn_in;
   logic [2*FW-1:0]            s3_pcs_ff, s3_pcs_in;

   work_type                   s4_cs_ff, s4_cs_in;
   work_type                   s4_sn_ff, s4_cn_ff;

   prod_type                   s5_pea_ff, s5_pea_in;
   prod_type                   s5_peb_ff, s5_peb_in;

   work_type                   s6_ea_ff, s6_ea_in;
   work_type                   s6_eb_ff, s6_eb_in;

   prod_type                   s7_pm_ff [3][3][2];
   prod_type                   s7_pm_in [3][3][2];
   prod_type                   s7_py_ff, s7_py_in;
   prod_type                   s7_p1_ff, s7_p1_in;
   prod_type                   s7_p2_ff, s7_p2_in;

   work_type                   s8_mul_ff [3][3];
   work_type                   s8_mul_in [3][3];
   work_type                   s8_bv_ff [3];
   work_type                   s8_bv_in [3];

   prod_type                   s9_pt_ff [3][3][3];
   prod_type                   s9_pt_in [3][3][3];
   prod_type                   s9_pa_ff [3][3];
   prod_type                   s9_pa_in [3][3];
   work_type                   s9_mul_ff [3][3];

   work_type                   s10_res_ff [12];
   work_type                   s10_res_in [12];

   out_type                    s11_out_ff [12];
   out_type                    s11_out_in [12];

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_DEPTH-1:1], accept};

   // stage 2: clamp controls, quantize hue, pick the coefficient set
   always_comb begin
      logic signed [FW:0]      sat_sum;
      logic signed [FW:0]      con_sum;
      logic signed [FW-1:0]    hq;
      logic signed [KW+16:0]   hprod;
      logic signed [KW+1:0]    kq;
      logic                    rgb;
      logic                    tv;
      sat_sum = (FW+1)'(s1_sat_ff) + (FW+1)'(16384);
      con_sum = (FW+1)'(s1_con_ff) + (FW+1)'(16384);
      priority if (sat_sum < 0) begin
         s2_sat_in = '0;
      end else if (sat_sum > (FW+1)'(32768)) begin
         s2_sat_in = FW'(32768);
      end else begin
         s2_sat_in = sat_sum[FW-1:0];
      end
      priority if (con_sum < 0) begin
         s2_con_in = '0;
      end else if (con_sum > (FW+1)'(32768)) begin
         s2_con_in = FW'(32768);
      end else begin
         s2_con_in = con_sum[FW-1:0];
      end
      priority if (s1_hue_ff < -FW'(16384)) begin
         hq = -FW'(16384);
      end else if (s1_hue_ff > FW'(16384)) begin
         hq = FW'(16384);
      end else begin
         hq = s1_hue_ff;
      end
      priority if (s1_bright_ff < -FW'(16384)) begin
         s2_bright_in = -FW'(16384);
      end else if (s1_bright_ff > FW'(16384)) begin
         s2_bright_in = FW'(16384);
      end else begin
         s2_bright_in = s1_bright_ff;
      end
      hprod = (KW+17)'(hq) * (KW+17)'(SINE_TABLE_SIZE) + (KW+17)'(16384);
      kq    = (KW+2)'(hprod >>> 15);
      if (kq < 0) begin
         s2_kk_in = KW'(kq + (KW+2)'(SINE_TABLE_SIZE));
      end else begin
         s2_kk_in = KW'(kq);
      end
      rgb = (s1_space_ff == SPACE_RGB);
      tv  = rgb || (s1_range_ff == RANGE_TV);
      unique case (s1_space_ff)
         SPACE_BT709:     ctl_in.cset = tv ? CS_709_TV : CS_709_PC;
         SPACE_SMPTE240M: ctl_in.cset = tv ? CS_240_TV : CS_240_PC;
         SPACE_BT601:     ctl_in.cset = tv ? CS_601_TV : CS_601_PC;
         default:         ctl_in.cset = CS_601_TV;
      endcase
      ctl_in.rgb   = rgb;
      ctl_in.tv    = tv;
      ctl_in.ident = (s1_space_ff > SPACE_SMPTE240M)
                     || (s1_range_ff != RANGE_TV && s1_range_ff != RANGE_PC);
   end

   // stage 3: sine/cosine lookup, contrast times saturation
   always_comb begin
      logic [1:0]    q;
      logic [QW-1:0] j;
      work_type      sv;
      work_type      cv;
      priority if (s2_kk_ff >= KW'(3 * QTR)) begin
         q = 2'd3;
         j = QW'(s2_kk_ff - KW'(3 * QTR));
      end else if (s2_kk_ff >= KW'(2 * QTR)) begin
         q = 2'd2;
         j = QW'(s2_kk_ff - KW'(2 * QTR));
      end else if (s2_kk_ff >= KW'(QTR)) begin
         q = 2'd1;
         j = QW'(s2_kk_ff - KW'(QTR));
      end else begin
         q = 2'd0;
         j = QW'(s2_kk_ff);
      end
      sv = work_type'(SIN_TAB[j]);
      cv = work_type'(COS_TAB[j]);
      unique case (q)
         2'd0: begin
            s3_sn_in = sv;
            s3_cn_in = cv;
         end
         2'd1: begin
            s3_sn_in = cv;
            s3_cn_in = -sv;
         end
         2'd2: begin
            s3_sn_in = -sv;
            s3_cn_in = -cv;
         end
         default: begin
            s3_sn_in = -cv;
            s3_cn_in = sv;
         end
      endcase
      s3_pcs_in = s2_con_ff * s2_sat_ff;
   end

   assign s4_cs_in  = work_type'((s3_pcs_ff + (2*FW)'(8)) >> 4);
   assign s5_pea_in = s4_cs_ff * s4_cn_ff;
   assign s5_peb_in = s4_cs_ff * s4_sn_ff;
   assign s6_ea_in  = round_work(sum_type'(s5_pea_ff));
   assign s6_eb_in  = round_work(sum_type'(s5_peb_ff));

   // stage 7: chroma rotation through YCbCr-to-RGB, offset partials
   always_comb begin
      work_type cw;
      coef_type y1w;
      coef_type cmw;
      cw  = work_type'({cpipe_ff[6], 10'b0});
      y1w = ctl_ff[6].tv ? Y1W_TV : '0;
      cmw = ctl_ff[6].tv ? CMW_TV : CMW_PC;
      for (int i = 0; i < 3; i++) begin
         s7_pm_in[i][0][0] = cw * y2r_coef(ctl_ff[6].cset, i, 0);
         s7_pm_in[i][0][1] = '0;
         s7_pm_in[i][1][0] = s6_ea_ff * y2r_coef(ctl_ff[6].cset, i, 1);
         s7_pm_in[i][1][1] = (-s6_eb_ff) * y2r_coef(ctl_ff[6].cset, i, 2);
         s7_pm_in[i][2][0] = s6_eb_ff * y2r_coef(ctl_ff[6].cset, i, 1);
         s7_pm_in[i][2][1] = s6_ea_ff * y2r_coef(ctl_ff[6].cset, i, 2);
      end
      s7_py_in = cw * y1w;
      s7_p1_in = (s6_ea_ff + s6_eb_ff) * cmw;
      s7_p2_in = (s6_ea_ff - s6_eb_ff) * cmw;
   end

   // stage 8: round matrix, form offset vector
   always_comb begin
      work_type bw;
      bw = work_type'({s8_bright_sx(bpipe_ff[7]), 10'b0});
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s8_mul_in[i][j] = round_work(sum_type'(s7_pm_ff[i][j][0])
                                         + sum_type'(s7_pm_ff[i][j][1]));
         end
      end
      if (ctl_ff[7].rgb) begin
         s8_bv_in[0] = bw;
         s8_bv_in[1] = '0;
         s8_bv_in[2] = '0;
      end else begin
         s8_bv_in[0] = bw - round_work(sum_type'(s7_py_ff));
         s8_bv_in[1] = -round_work(sum_type'(s7_p1_ff));
         s8_bv_in[2] = -round_work(sum_type'(s7_p2_ff));
      end
   end

   function automatic logic signed [WW-11:0] s8_bright_sx(input logic signed [FW-1:0] v);
      return (WW-10)'(v);
   endfunction

   // stage 9: RGB-to-YCbCr products, offset products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               s9_pt_in[i][j][k] = s8_mul_ff[i][k] * coef_type'(R2Y_TAB[k][j]);
            end
            s9_pa_in[i][j] = s8_bv_ff[j] * y2r_coef(ctl_ff[8].cset, i, j);
         end
      end
   end

   // stage 10: final sums, identity override
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (ctl_ff[9].ident) begin
               s10_res_in[i*3+j] = (i == j) ? work_type'(ONE) : '0;
            end else if (ctl_ff[9].rgb) begin
               s10_res_in[i*3+j] = round_work(sum_type'(s9_pt_ff[i][j][0])
                                              + sum_type'(s9_pt_ff[i][j][1])
                                              + sum_type'(s9_pt_ff[i][j][2]));
            end else begin
               s10_res_in[i*3+j] = s9_mul_ff[i][j];
            end
         end
         if (ctl_ff[9].ident) begin
            s10_res_in[9+i] = '0;
         end else begin
            s10_res_in[9+i] = round_work(sum_type'(s9_pa_ff[i][0])
                                         + sum_type'(s9_pa_ff[i][1])
                                         + sum_type'(s9_pa_ff[i][2]));
         end
      end
   end

   // stage 11: round to output format and saturate
   always_comb begin
      for (int n = 0; n < 12; n++) begin
         s11_out_in[n] = emit_out(s10_res_ff[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_space_ff  <= req_color_space;
      s1_range_ff  <= req_level_range;
      s1_bright_ff <= req_brightness;
      s1_sat_ff    <= req_saturation_adjust;
      s1_hue_ff    <= req_hue_adjust;
      s1_con_ff    <= req_contrast_adjust;

      ctl_ff[2] <= ctl_in;
      for (int n = 3; n <= 9; n++) begin
         ctl_ff[n] <= ctl_ff[n-1];
      end

      s2_sat_ff    <= s2_sat_in;
      s2_con_ff    <= s2_con_in;
      s2_bright_ff <= s2_bright_in;
      s2_kk_ff     <= s2_kk_in;

      cpipe_ff[3] <= s2_con_ff;
      bpipe_ff[3] <= s2_bright_ff;
      for (int n = 4; n <= 6; n++) begin
         cpipe_ff[n] <= cpipe_ff[n-1];
      end
      for (int n = 4; n <= 7; n++) begin
         bpipe_ff[n] <= bpipe_ff[n-1];
      end

      s3_sn_ff  <= s3_sn_in;
      s3_cn_ff  <= s3_cn_in;
      s3_pcs_ff <= s3_pcs_in;

      s4_cs_ff <= s4_cs_in;
      s4_sn_ff <= s3_sn_ff;
      s4_cn_ff <= s3_cn_ff;

      s5_pea_ff <= s5_pea_in;
      s5_peb_ff <= s5_peb_in;

      s6_ea_ff <= s6_ea_in;
      s6_eb_ff <= s6_eb_in;

      s7_pm_ff <= s7_pm_in;
      s7_py_ff <= s7_py_in;
      s7_p1_ff <= s7_p1_in;
      s7_p2_ff <= s7_p2_in;

      s8_mul_ff <= s8_mul_in;
      s8_bv_ff  <= s8_bv_in;

      s9_pt_ff  <= s9_pt_in;
      s9_pa_ff  <= s9_pa_in;
      s9_mul_ff <= s8_mul_ff;

      s10_res_ff <= s10_res_in;
      s11_out_ff <= s11_out_in;
   end

   assign rsp_strobe       = vld_ff[PIPE_DEPTH];
   assign rsp_m00          = s11_out_ff[0];
   assign rsp_m01          = s11_out_ff[1];
   assign rsp_m02          = s11_out_ff[2];
   assign rsp_m10          = s11_out_ff[3];
   assign rsp_m11          = s11_out_ff[4];
   assign rsp_m12          = s11_out_ff[5];
   assign rsp_m20          = s11_out_ff[6];
   assign rsp_m21          = s11_out_ff[7];
   assign rsp_m22          = s11_out_ff[8];
   assign rsp_offset_red   = s11_out_ff[9];
   assign rsp_offset_green = s11_out_ff[10];
   assign rsp_offset_blue  = s11_out_ff[11];

   `CAMG_ASSERT_DELAY(a_beat_latency, start && !busy, PIPE_DEPTH, rsp_strobe)
   `CAMG_ASSERT_IMPLY(a_no_spurious, rsp_strobe, $past(start && !busy, PIPE_DEPTH))
   `CAMG_ASSERT_IMPLY(a_identity, rsp_strobe && $past(start && !busy && (req_color_space > SPACE_SMPTE240M), PIPE_DEPTH), rsp_m00 == IDENT_OUT && rsp_m01 == '0 && rsp_offset_red == '0)

endmodule

// ----- tb/color_adjust_matrix_generator_tb.sv -----
// ----------------------------------------------------------------------------
// Color adjust matrix generator testbench
// Drives color space, level range and picture control commands, predicts the
// matrix and offset set of each one in fixed point, and checks every result.
// ----------------------------------------------------------------------------
module color_adjust_matrix_generator_tb;
   import camg_pkg::out_type;
   import camg_pkg::FW;

   typedef struct {
      out_type v [12];
   } coef_set_t;

   localparam int         TRIG_STEPS   = 256;
   localparam int         FRAC_OUT     = 14;
   localparam int         WFRAC        = 24;
   localparam longint     UNIT         = longint'(1) << WFRAC;
   localparam longint unsigned Q30_ONE  = 64'd1073741824;
   localparam longint unsigned Q30_HPI  = 64'd1686629713;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 30;

   localparam logic [2:0] CS_RGB   = 3'd0;
   localparam logic [2:0] CS_601   = 3'd1;
   localparam logic [2:0] CS_709   = 3'd2;
   localparam logic [2:0] CS_240   = 3'd3;
   localparam logic [1:0] LR_AUTO  = 2'd0;
   localparam logic [1:0] LR_TV    = 2'd1;
   localparam logic [1:0] LR_PC    = 2'd2;
   localparam logic [1:0] LR_BAD   = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [2:0]           req_color_space;
   logic [1:0]           req_level_range;
   logic signed [FW-1:0] req_brightness;
   logic signed [FW-1:0] req_saturation_adjust;
   logic signed [FW-1:0] req_hue_adjust;
   logic signed [FW-1:0] req_contrast_adjust;
   logic                 rsp_strobe;
   out_type              rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   out_type              rsp_m20, rsp_m21, rsp_m22;
   out_type              rsp_offset_red, rsp_offset_green, rsp_offset_blue;

   coef_set_t pending_sets [$];
   int        error_count;
   int        quiet_cycles;
   int        sender_idle_pct;

   color_adjust_matrix_generator DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_color_space       (req_color_space),
      .req_level_range       (req_level_range),
      .req_brightness        (req_brightness),
      .req_saturation_adjust (req_saturation_adjust),
      .req_hue_adjust        (req_hue_adjust),
      .req_contrast_adjust   (req_contrast_adjust),
      .rsp_strobe            (rsp_strobe),
      .rsp_m00               (rsp_m00),
      .rsp_m01               (rsp_m01),
      .rsp_m02               (rsp_m02),
      .rsp_m10               (rsp_m10),
      .rsp_m11               (rsp_m11),
      .rsp_m12               (rsp_m12),
      .rsp_m20               (rsp_m20),
      .rsp_m21               (rsp_m21),
      .rsp_m22               (rsp_m22),
      .rsp_offset_red        (rsp_offset_red),
      .rsp_offset_green      (rsp_offset_green),
      .rsp_offset_blue       (rsp_offset_blue)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint fdiv(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint round_div(input longint num, input longint den);
      return fdiv(2 * num + den, 2 * den);
   endfunction

   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned series_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned dv [5];
      dv = '{110, 72, 42, 20, 6};
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         t = Q30_ONE - ((x2 * t) >> 30) / dv[i];
      end
      return (x * t) >> 30;
   endfunction

   function automatic void hue_sin_cos(input longint k, output longint sn, output longint cs);
      longint          kk;
      longint          quad;
      longint unsigned rem;
      longint unsigned x;
      longint          s;
      longint          c;
      kk   = ((k % TRIG_STEPS) + TRIG_STEPS) % TRIG_STEPS;
      quad = (4 * kk) / TRIG_STEPS;
      rem  = longint'((4 * kk) % TRIG_STEPS);
      x    = (rem * Q30_HPI + TRIG_STEPS / 2) / TRIG_STEPS;
      s    = longint'((series_sine(x) + 32) >> 6);
      c    = longint'((series_sine(Q30_HPI - x) + 32) >> 6);
      case (quad & 3)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic out_type to_output(input longint w);
      return out_type'(clip(round_shift(w, WFRAC - FRAC_OUT), -524288, 524287));
   endfunction

   function automatic coef_set_t predict_coefs(input logic [2:0] space, input logic [1:0] lvl,
                                               input longint br, input longint sat,
                                               input longint hue, input longint con);
      coef_set_t r;
      longint y2r [3][3];
      longint r2y [3][3];
      longint shc [3][3];
      longint mm  [3][3];
      longint tm  [3][3];
      longint bv  [3];
      longint d, y1n, y2n, c1n, c2n, kb, kr, kg, dyn, dcn;
      longint s, c, h, b, sn, cn, cs, ea, eb, y1w, cmw, acc;
      bit     rgb;
      foreach (r.v[i]) r.v[i] = '0;
      if (space > CS_240 || (lvl != LR_TV && lvl != LR_PC)) begin
         r.v[0] = to_output(UNIT);
         r.v[4] = to_output(UNIT);
         r.v[8] = to_output(UNIT);
         return r;
      end
      rgb = (space == CS_RGB);
      if (rgb || lvl == LR_TV) begin
         d = 255; y1n = 16; y2n = 235; c1n = 16; c2n = 240;
      end else begin
         d = 1; y1n = 0; y2n = 1; c1n = 0; c2n = 1;
      end
      case (space)
         CS_709:  begin kb = 722;  kr = 2126; end
         CS_240:  begin kb = 870;  kr = 2120; end
         default: begin kb = 1140; kr = 2990; end
      endcase
      kg  = 10000 - kb - kr;
      dyn = y2n - y1n;
      dcn = c2n - c1n;

      y2r[0][0] = round_div(d * UNIT, dyn);
      y2r[1][0] = y2r[0][0];
      y2r[2][0] = y2r[0][0];
      y2r[0][1] = 0;
      y2r[0][2] = round_div(2 * d * (10000 - kr) * UNIT, 10000 * dcn);
      y2r[1][1] = round_div(-2 * d * (10000 - kb) * kb * UNIT, dcn * 10000 * kg);
      y2r[1][2] = round_div(-2 * d * (10000 - kr) * kr * UNIT, dcn * 10000 * kg);
      y2r[2][1] = round_div(2 * d * (10000 - kb) * UNIT, 10000 * dcn);
      y2r[2][2] = 0;

      r2y[0][0] = round_div(dyn * kr * UNIT, d * 10000);
      r2y[0][1] = round_div(dyn * kg * UNIT, d * 10000);
      r2y[0][2] = round_div(dyn * kb * UNIT, d * 10000);
      r2y[1][0] = round_div(-dcn * kr * UNIT, 2 * d * (10000 - kb));
      r2y[1][1] = round_div(-dcn * kg * UNIT, 2 * d * (10000 - kb));
      r2y[1][2] = round_div(dcn * UNIT, 2 * d);
      r2y[2][0] = round_div(dcn * UNIT, 2 * d);
      r2y[2][1] = round_div(-dcn * kg * UNIT, 2 * d * (10000 - kr));
      r2y[2][2] = round_div(-dcn * kb * UNIT, 2 * d * (10000 - kr));

      s = clip(sat + 16384, 0, 32768) * 1024;
      c = clip(con + 16384, 0, 32768) * 1024;
      h = clip(hue, -16384, 16384);
      b = clip(br, -16384, 16384) * 1024;
      hue_sin_cos(fdiv(h * TRIG_STEPS + 16384, 32768), sn, cn);

      cs = round_shift(c * s, WFRAC);
      ea = round_shift(cs * cn, WFRAC);
      eb = round_shift(cs * sn, WFRAC);
      shc = '{'{c, 0, 0}, '{0, ea, eb}, '{0, -eb, ea}};

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += y2r[i][k] * shc[k][j];
            mm[i][j] = round_shift(acc, WFRAC);
         end
      end

      bv = '{b, 0, 0};
      if (rgb) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int k = 0; k < 3; k++) acc += mm[i][k] * r2y[k][j];
               tm[i][j] = round_shift(acc, WFRAC);
            end
         end
         mm = tm;
      end else begin
         y1w   = round_div(y1n * UNIT, d);
         cmw   = round_div((c1n + c2n) * UNIT, 2 * d);
         bv[0] = b - round_shift(c * y1w, WFRAC);
         bv[1] = -round_shift(ea * cmw + eb * cmw, WFRAC);
         bv[2] = -round_shift(ea * cmw - eb * cmw, WFRAC);
      end

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) r.v[i * 3 + j] = to_output(mm[i][j]);
         acc = 0;
         for (int k = 0; k < 3; k++) acc += y2r[i][k] * bv[k];
         r.v[9 + i] = to_output(round_shift(acc, WFRAC));
      end
      return r;
   endfunction

   // one command beat; called and returns at a falling edge
   task automatic send_command(input logic [2:0] space, input logic [1:0] lvl,
                               input logic signed [15:0] br, input logic signed [15:0] sat,
                               input logic signed [15:0] hue, input logic signed [15:0] con);
      bit taken;
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct && gap < 8) begin
         start = 1'b0;
         @(negedge clock);
         gap++;
      end
      req_color_space       = space;
      req_level_range       = lvl;
      req_brightness        = br;
      req_saturation_adjust = sat;
      req_hue_adjust        = hue;
      req_contrast_adjust   = con;
      start                 = 1'b1;
      forever begin
         taken = !busy;
         @(posedge clock);
         if (taken) break;
         @(negedge clock);
      end
      pending_sets.push_back(predict_coefs(space, lvl, longint'(br), longint'(sat),
                                           longint'(hue), longint'(con)));
      quiet_cycles = 0;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_control();
      case ($urandom_range(0, 5))
         0, 1:    return 16'($urandom);
         2:       return 16'(int'($urandom_range(0, 32768)) - 16384);
         3: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7fff;
               2:       return 16'shc000;
               3:       return 16'sh4000;
               default: return 16'sh0000;
            endcase
         end
         default: return 16'(int'($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] ext [5];
      ext = '{16'sh8000, 16'sh7fff, 16'shc000, 16'sh4000, 16'sh0000};
      sender_idle_pct = 0;
      send_command(3'd4, LR_TV, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000);
      send_command(3'd7, LR_PC, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_command(CS_601, LR_AUTO, 16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_command(CS_RGB, LR_BAD, 16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_command(CS_RGB, LR_PC, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      for (int sp = 0; sp < 4; sp++) begin
         send_command(3'(sp), LR_TV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
         send_command(3'(sp), LR_PC, 16'sh0800, 16'sh1000, 16'sh2000, 16'shf000);
      end
      for (int e = 0; e < 5; e++) begin
         send_command(CS_709, LR_TV, ext[e], ext[e], ext[e], ext[e]);
         send_command(CS_RGB, LR_TV, ext[e], ext[(e + 1) % 5], ext[(e + 2) % 5],
                      ext[(e + 3) % 5]);
      end
      send_command(CS_240, LR_PC, 16'sh4000, 16'sh7fff, 16'sh8000, 16'sh7fff);
   endtask

   task automatic test_random(input int idle_pct, input int count);
      logic [2:0] space;
      logic [1:0] lvl;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            space = 3'($urandom);
            lvl   = 2'($urandom);
         end else begin
            space = 3'($urandom_range(0, 3));
            lvl   = 2'($urandom_range(1, 2));
         end
         send_command(space, lvl, rand_control(), rand_control(), rand_control(),
                      rand_control());
      end
   endtask

   always @(posedge clock) begin
      out_type   got [12];
      coef_set_t want;
      if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
      if (!reset && rsp_strobe) begin
         quiet_cycles <= 0;
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12, rsp_m20, rsp_m21,
                 rsp_m22, rsp_offset_red, rsp_offset_green, rsp_offset_blue};
         if (pending_sets.size() == 0) begin
            $display("%0t: result beat with nothing pending", $time);
            error_count++;
         end else begin
            want = pending_sets.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (got[i] !== want.v[i]) begin
                  $display("%0t: field %0d expected %0d actual %0d", $time, i,
                           want.v[i], got[i]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      error_count           = 0;
      quiet_cycles          = 0;
      sender_idle_pct       = 0;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_color_space       = '0;
      req_level_range       = '0;
      req_brightness        = '0;
      req_saturation_adjust = '0;
      req_hue_adjust        = '0;
      req_contrast_adjust   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(29, 700);
      test_random(45, 650);
      test_random(0, 650);
      start = 1'b0;

      while (pending_sets.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
